[rtl/core/tlpw_pkg.sv]
// Package: shared constants, types and helpers for the two-level page walk MMU.
`timescale 1ns / 1ps
package tlpw_pkg;

	localparam int MEM_ADDR_BITS = 16;
	localparam logic [33:0] MEM_BYTES = 34'd1 << MEM_ADDR_BITS;

	typedef enum logic [1:0] {
		OP_PHYS_RD = 2'd0,
		OP_PHYS_WR = 2'd1,
		OP_VIRT_RD = 2'd2,
		OP_VIRT_WR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_PDE  = 2'd1,
		ST_NO_PTE  = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	typedef enum logic {
		CFG_PAGING_EN = 1'b0,
		CFG_PDIR_BASE = 1'b1
	} cfg_idx_t;

	localparam logic [7:0] PTE_ACCESSED = 8'h20;
	localparam logic [7:0] PTE_DIRTY    = 8'h40;

	// Memory request driven by the sequencer.
	typedef struct packed {
		logic                     we;
		logic [MEM_ADDR_BITS-1:0] addr;
		logic [7:0]               wdata;
	} mem_req_t;

	// True when n bytes starting at a lie inside the memory.
	function automatic logic fits(input logic [32:0] a, input logic [2:0] n);
		logic [33:0] e;
		e = {1'b0, a} + 34'(n);
		return e <= MEM_BYTES;
	endfunction

endpackage

[rtl/core/two_level_page_walk_mmu_core.sv]
// Top level: byte memory with two-level page walker and access sequencer.
`timescale 1ns / 1ps
//
// Channel   | Handshake                      | Payload
// ----------+--------------------------------+------------------------------------------
// command   | start, busy (accept: start&!busy) | opcode, address, access_length, write_data
// result    | result_valid (one-cycle strobe)   | read_data, status
// config    | cfg_valid, cfg_ready              | cfg_index, cfg_data
//
// Everything goes through one byte-wide RAM port, one byte per cycle.
// Per translation: 4 directory byte reads, 4 table byte reads, a wait and a check
// after each entry; the table write-back shares the second check state.
// Per part: setup and range check, then the data bytes, plus a wait after reads.
// Unpaged accesses skip the walk; a length of zero goes straight to the result.
// A split paged 4-byte read is the worst case.
// After reset the memory is zeroed by a sweep over every address (busy high);
// config words are taken at any time. Results cannot be stalled.
module two_level_page_walk_mmu_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [31:0] address,
	input  logic [2:0]  access_length,
	input  logic [31:0] write_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output logic        result_valid,
	output logic [31:0] read_data,
	output logic [1:0]  status
);
	import tlpw_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_PART, S_DIR_RD, S_DIR_WT, S_DIR_CHK,
		S_TAB_RD, S_TAB_WT, S_TAB_CHK, S_DATA_CHK, S_DATA_RD, S_DATA_WT,
		S_DATA_WR, S_DONE
	} state_t;

	localparam int AW = MEM_ADDR_BITS;

	state_t         state_q;
	logic [AW-1:0]  clr_q;
	logic [1:0]     op_q;
	logic [31:0]    addr_q, wdata_q, va_q, pa_q, ent_q, res_q;
	logic [2:0]     len_q, done_q, n_q, k_q;
	logic [AW-1:0]  base_q;
	logic [1:0]     stat_q;
	logic           pg_en_q;
	logic [31:0]    pdb_q;
	logic           cap_v_s1, cap_ent_s1;
	logic [1:0]     cap_idx_s1;

	mem_req_t       req;
	logic [7:0]     mem_rdata;

	// per-part setup values
	logic [12:0]    offs_end;
	logic [2:0]     first_n, part_n, len_sat, cnt;
	logic [31:0]    part_va;
	logic [32:0]    dir_at, tab_at;
	logic [1:0]     wbyte_idx;
	logic [31:0]    wshift;
	logic           last_k;

	tlpw_ram #(.AW(AW), .DW(8)) u_ram (
		.clk   (clk),
		.we    (req.we),
		.addr  (req.addr),
		.wdata (req.wdata),
		.rdata (mem_rdata)
	);

	assign cfg_ready = 1'b1;
	assign busy = (state_q != S_IDLE);
	assign result_valid = (state_q == S_DONE);
	assign status = stat_q;
	assign read_data = (op_q[0] || stat_q != ST_OK) ? 32'd0 : res_q;

	assign len_sat = (access_length > 3'd4) ? 3'd4 : access_length;
	assign offs_end = {1'b0, addr_q[11:0]} + 13'(len_q);
	assign first_n = (offs_end > 13'h1000) ? 3'(13'h1000 - {1'b0, addr_q[11:0]}) : len_q;
	assign part_n = (done_q == 3'd0) ? first_n : 3'(len_q - done_q);
	assign part_va = addr_q + 32'(done_q);
	assign dir_at = {1'b0, pdb_q[31:12], 12'd0} + 33'({part_va[31:22], 2'b00});
	assign tab_at = {1'b0, ent_q[31:12], 12'd0} + 33'({va_q[21:12], 2'b00});
	assign wbyte_idx = done_q[1:0] + k_q[1:0];
	assign wshift = wdata_q >> {wbyte_idx, 3'b000};
	assign cnt = (state_q == S_DATA_RD || state_q == S_DATA_WR) ? n_q : 3'd4;
	assign last_k = (k_q == 3'(cnt - 3'd1));

	// memory port steering
	always_comb begin
		req.we    = 1'b0;
		req.addr  = base_q + AW'(k_q[1:0]);
		req.wdata = 8'd0;
		unique case (state_q)
			S_CLEAR: begin
				req.we   = 1'b1;
				req.addr = clr_q;
			end
			S_TAB_CHK: begin
				req.we    = ent_q[0];
				req.addr  = base_q;
				req.wdata = ent_q[7:0] | PTE_ACCESSED | (op_q[0] ? PTE_DIRTY : 8'd0);
			end
			S_DATA_WR: begin
				req.we    = 1'b1;
				req.wdata = wshift[7:0];
			end
			default: begin
			end
		endcase
	end

	// read capture, in the cycle after the address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_v_s1 <= 1'b0;
		end else begin
			cap_v_s1 <= (state_q == S_DIR_RD || state_q == S_TAB_RD || state_q == S_DATA_RD);
		end
	end

	always_ff @(posedge clk) begin
		cap_ent_s1 <= (state_q != S_DATA_RD);
		cap_idx_s1 <= (state_q == S_DATA_RD) ? wbyte_idx : k_q[1:0];
		if (cap_v_s1) begin
			if (cap_ent_s1) begin
				ent_q[{cap_idx_s1, 3'b000} +: 8] <= mem_rdata;
			end else begin
				res_q[{cap_idx_s1, 3'b000} +: 8] <= mem_rdata;
			end
		end else if (state_q == S_IDLE) begin
			res_q <= 32'd0;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pg_en_q <= 1'b0;
			pdb_q   <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PAGING_EN: pg_en_q <= cfg_data[0];
				CFG_PDIR_BASE: pdb_q   <= cfg_data;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			stat_q  <= ST_OK;
			op_q    <= OP_PHYS_RD;
			k_q     <= 3'd0;
			done_q  <= 3'd0;
			len_q   <= 3'd0;
			n_q     <= 3'd0;
			addr_q  <= 32'd0;
			wdata_q <= 32'd0;
			va_q    <= 32'd0;
			pa_q    <= 32'd0;
			base_q  <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q    <= opcode;
						addr_q  <= address;
						len_q   <= len_sat;
						wdata_q <= write_data;
						done_q  <= 3'd0;
						stat_q  <= ST_OK;
						state_q <= (len_sat == 3'd0) ? S_DONE : S_PART;
					end
				end
				S_PART: begin
					k_q <= 3'd0;
					va_q <= part_va;
					if (!op_q[1]) begin
						n_q     <= len_q;
						pa_q    <= addr_q;
						state_q <= S_DATA_CHK;
					end else begin
						n_q <= part_n;
						if (!pg_en_q) begin
							pa_q    <= part_va;
							state_q <= S_DATA_CHK;
						end else if (!fits(dir_at, 3'd4)) begin
							stat_q  <= ST_RANGE;
							state_q <= S_DONE;
						end else begin
							base_q  <= dir_at[AW-1:0];
							state_q <= S_DIR_RD;
						end
					end
				end
				S_DIR_RD, S_TAB_RD, S_DATA_RD: begin
					k_q <= k_q + 3'd1;
					if (last_k) begin
						state_q <= (state_q == S_DIR_RD) ? S_DIR_WT :
							(state_q == S_TAB_RD) ? S_TAB_WT : S_DATA_WT;
					end
				end
				S_DIR_WT: state_q <= S_DIR_CHK;
				S_TAB_WT: state_q <= S_TAB_CHK;
				S_DIR_CHK: begin
					k_q <= 3'd0;
					if (!ent_q[0]) begin
						stat_q  <= ST_NO_PDE;
						state_q <= S_DONE;
					end else if (!fits(tab_at, 3'd4)) begin
						stat_q  <= ST_RANGE;
						state_q <= S_DONE;
					end else begin
						base_q  <= tab_at[AW-1:0];
						state_q <= S_TAB_RD;
					end
				end
				S_TAB_CHK: begin
					if (!ent_q[0]) begin
						stat_q  <= ST_NO_PTE;
						state_q <= S_DONE;
					end else begin
						pa_q    <= {ent_q[31:12], va_q[11:0]};
						state_q <= S_DATA_CHK;
					end
				end
				S_DATA_CHK: begin
					k_q <= 3'd0;
					if (!fits({1'b0, pa_q}, n_q)) begin
						stat_q  <= ST_RANGE;
						state_q <= S_DONE;
					end else begin
						base_q  <= pa_q[AW-1:0];
						state_q <= op_q[0] ? S_DATA_WR : S_DATA_RD;
					end
				end
				S_DATA_WT, S_DATA_WR: begin
					k_q <= k_q + 3'd1;
					if (state_q == S_DATA_WT || last_k) begin
						done_q  <= done_q + n_q;
						state_q <= (3'(done_q + n_q) < len_q) ? S_PART : S_DONE;
					end
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted command did not raise busy");
	a_strobe_once: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result strobe longer than a cycle");
	a_write_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && op_q[0]) |-> (read_data == 32'd0))
		else $error("write returned nonzero read data");
`endif

endmodule

[rtl/core/tlpw_ram.sv]
// Generic single-port synchronous RAM, registered read data.
`timescale 1ns / 1ps
module tlpw_ram #(
	parameter int AW = 16,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [(1 << AW)];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
